FILE: design/plt_pkg.sv
// Shared types, constants and the arctangent table of the perpendicular line block.
package plt_pkg;

	// Coordinate width of every input and output point
	localparam int COORD_BITS = 32;
	// Vector width inside the datapath: difference plus normalize headroom and CORDIC growth
	localparam int VEC_W = 44;
	// Angle width: signed radians scaled by 2^30, room for a full turn either way
	localparam int ANG_W = 36;
	// Normalize shift count width
	localparam int SH_W = 6;
	// A normalized vector has its larger magnitude at or above 2^NORM_EXP
	localparam int NORM_EXP = 40;
	// Error and tolerance width, Q1.16 radians
	localparam int ERR_W = 17;

	localparam logic signed [ANG_W-1:0] ANG_PI = 36'sd3373259426;
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 36'sd1686629713;
	localparam logic signed [ANG_W-1:0] ANG_TWO_PI = 36'sd6746518852;
	// Limit CORDIC gain inverse, scaled by 2^30
	localparam logic [29:0] GAIN_INV = 30'd652032874;
	localparam logic [ERR_W-1:0] ERR_MAX = '1;
	localparam logic [ERR_W-1:0] TOL_RESET = 17'd66;

	// One request: two segments
	typedef struct packed {
		logic signed [COORD_BITS-1:0] first_start_x;
		logic signed [COORD_BITS-1:0] first_start_y;
		logic signed [COORD_BITS-1:0] first_end_x;
		logic signed [COORD_BITS-1:0] first_end_y;
		logic signed [COORD_BITS-1:0] second_start_x;
		logic signed [COORD_BITS-1:0] second_start_y;
		logic signed [COORD_BITS-1:0] second_end_x;
		logic signed [COORD_BITS-1:0] second_end_y;
	} request_t;

	// One result
	typedef struct packed {
		logic                         lines_valid;
		logic [ERR_W-1:0]             angle_error;
		logic                         is_satisfied;
		logic signed [COORD_BITS-1:0] new_end_x;
		logic signed [COORD_BITS-1:0] new_end_y;
		logic                         was_saturated;
	} result_t;

	// Fields that ride alongside the datapath from input to output
	typedef struct packed {
		logic                         deg;
		logic signed [COORD_BITS-1:0] px;
		logic signed [COORD_BITS-1:0] py;
		logic signed [COORD_BITS-1:0] ex;
		logic signed [COORD_BITS-1:0] ey;
	} side_t;

	// floor(atan(2^-idx) * 2^30)
	function automatic logic signed [ANG_W-1:0] atan_entry(input int unsigned idx);
		logic signed [ANG_W-1:0] a;
		unique case (idx)
			0: a = 36'sd843314856;
			1: a = 36'sd497837829;
			2: a = 36'sd263043836;
			3: a = 36'sd133525158;
			4: a = 36'sd67021686;
			5: a = 36'sd33543515;
			6: a = 36'sd16775850;
			7: a = 36'sd8388437;
			8: a = 36'sd4194282;
			9: a = 36'sd2097149;
			10: a = 36'sd1048575;
			11: a = 36'sd524287;
			12: a = 36'sd262143;
			13: a = 36'sd131071;
			14: a = 36'sd65535;
			15: a = 36'sd32767;
			16: a = 36'sd16383;
			17: a = 36'sd8191;
			18: a = 36'sd4095;
			19: a = 36'sd2047;
			20: a = 36'sd1023;
			21: a = 36'sd511;
			22: a = 36'sd255;
			23: a = 36'sd127;
			24: a = 36'sd63;
			25: a = 36'sd31;
			26: a = 36'sd15;
			27: a = 36'sd7;
			28: a = 36'sd3;
			29: a = 36'sd1;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

FILE: design/perpendicular_line_enforce.sv
// Top level: perpendicularity check and correction of two segments, fully pipelined.
//
// A request is taken on every cycle that start is high; busy never rises. Each result
// sits on result with done high for one cycle, once its request has passed every stage.
// The result must be taken then: there is no backpressure. The datapath runs through two
// rows of CORDIC cells in series (vectoring for both directions, then rotation of line two),
// each one cell per stage, plus normalize, angle and output stages. angle_tolerance is written
// through cfg_we/cfg_data and should be changed only while no request is in flight.
module perpendicular_line_enforce #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  plt_pkg::request_t            req,
	input  logic                         cfg_we,
	input  logic [plt_pkg::ERR_W-1:0]    cfg_data,
	output logic                         done,
	output plt_pkg::result_t             result
);

	localparam int VW = plt_pkg::VEC_W;
	localparam int AW = plt_pkg::ANG_W;
	localparam int CB = plt_pkg::COORD_BITS;
	localparam int LATENCY = 2 * CORDIC_STAGES + 10;

	// Control
	logic [LATENCY-1:0]         vld_q;
	logic [plt_pkg::ERR_W-1:0]  tol_q;

	assign busy = 1'b0;
	assign done = vld_q[LATENCY-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			tol_q <= plt_pkg::TOL_RESET;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], start && !busy};
			if (cfg_we) begin
				tol_q <= cfg_data;
			end
		end
	end

	// Stage 1: direction vectors and degenerate check
	logic signed [VW-1:0] dx1_s1, dy1_s1, dx2_s1, dy2_s1;
	plt_pkg::side_t       side_s1;

	always_ff @(posedge clk) begin
		dx1_s1 <= VW'(req.first_end_x) - VW'(req.first_start_x);
		dy1_s1 <= VW'(req.first_end_y) - VW'(req.first_start_y);
		dx2_s1 <= VW'(req.second_end_x) - VW'(req.second_start_x);
		dy2_s1 <= VW'(req.second_end_y) - VW'(req.second_start_y);
		side_s1.deg <= (req.first_end_x == req.first_start_x
			&& req.first_end_y == req.first_start_y)
			|| (req.second_end_x == req.second_start_x
			&& req.second_end_y == req.second_start_y);
		side_s1.px <= req.second_start_x;
		side_s1.py <= req.second_start_y;
		side_s1.ex <= req.second_end_x;
		side_s1.ey <= req.second_end_y;
	end

	// Stages 2-4: normalize both vectors
	logic signed [VW-1:0]      x1n, y1n, x2n, y2n;
	logic [plt_pkg::SH_W-1:0]  sh2;

	plt_norm u_norm1 (
		.clk    (clk),
		.x_in   (dx1_s1),
		.y_in   (dy1_s1),
		.x_out  (x1n),
		.y_out  (y1n),
		.sh_out ()
	);

	plt_norm u_norm2 (
		.clk    (clk),
		.x_in   (dx2_s1),
		.y_in   (dy2_s1),
		.x_out  (x2n),
		.y_out  (y2n),
		.sh_out (sh2)
	);

	// Stage 5: quarter-turn prerotation into the right half plane, gain partial products
	logic signed [VW-1:0] v1x [CORDIC_STAGES+1];
	logic signed [VW-1:0] v1y [CORDIC_STAGES+1];
	logic signed [AW-1:0] v1z [CORDIC_STAGES+1];
	logic signed [VW-1:0] v2x [CORDIC_STAGES+1];
	logic signed [VW-1:0] v2y [CORDIC_STAGES+1];
	logic signed [AW-1:0] v2z [CORDIC_STAGES+1];

	always_ff @(posedge clk) begin
		if (!x1n[VW-1]) begin
			v1x[0] <= x1n;
			v1y[0] <= y1n;
			v1z[0] <= '0;
		end else if (!y1n[VW-1]) begin
			v1x[0] <= y1n;
			v1y[0] <= -x1n;
			v1z[0] <= plt_pkg::ANG_HALF_PI;
		end else begin
			v1x[0] <= -y1n;
			v1y[0] <= x1n;
			v1z[0] <= -plt_pkg::ANG_HALF_PI;
		end
		if (!x2n[VW-1]) begin
			v2x[0] <= x2n;
			v2y[0] <= y2n;
			v2z[0] <= '0;
		end else if (!y2n[VW-1]) begin
			v2x[0] <= y2n;
			v2y[0] <= -x2n;
			v2z[0] <= plt_pkg::ANG_HALF_PI;
		end else begin
			v2x[0] <= -y2n;
			v2y[0] <= x2n;
			v2z[0] <= -plt_pkg::ANG_HALF_PI;
		end
	end

	// Gain compensation: v times the inverse gain, split at bit 20 into two narrow products
	localparam int HI_W = VW - 20;
	localparam int PH_W = HI_W + 31;
	localparam logic signed [30:0] GAIN_S = $signed({1'b0, plt_pkg::GAIN_INV});

	logic signed [HI_W-1:0] hx, hy;
	logic signed [PH_W-1:0] phx_s5, phy_s5;
	logic [49:0]            plx_s5, ply_s5;
	logic signed [PH_W-1:0] sumx, sumy;
	logic signed [VW-1:0]   gx_s6, gy_s6;

	assign hx = x2n[VW-1:20];
	assign hy = y2n[VW-1:20];

	always_ff @(posedge clk) begin
		phx_s5 <= hx * GAIN_S;
		phy_s5 <= hy * GAIN_S;
		plx_s5 <= x2n[19:0] * plt_pkg::GAIN_INV;
		ply_s5 <= y2n[19:0] * plt_pkg::GAIN_INV;
	end

	assign sumx = phx_s5 + PH_W'($signed({1'b0, plx_s5[49:20]}));
	assign sumy = phy_s5 + PH_W'($signed({1'b0, ply_s5[49:20]}));

	always_ff @(posedge clk) begin
		gx_s6 <= sumx[VW+9:10];
		gy_s6 <= sumy[VW+9:10];
	end

	// Vectoring rows for both directions
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
		plt_cordic_cell #(.SHIFT(i), .VECTORING(1'b1)) u_cell1 (
			.clk   (clk),
			.x_in  (v1x[i]), .y_in (v1y[i]), .z_in (v1z[i]),
			.x_out (v1x[i+1]), .y_out (v1y[i+1]), .z_out (v1z[i+1])
		);
		plt_cordic_cell #(.SHIFT(i), .VECTORING(1'b1)) u_cell2 (
			.clk   (clk),
			.x_in  (v2x[i]), .y_in (v2y[i]), .z_in (v2z[i]),
			.x_out (v2x[i+1]), .y_out (v2y[i+1]), .z_out (v2z[i+1])
		);
	end

	// Stages 6-8: difference, wrap to (-pi, pi], rotation to the nearest quarter turn
	logic signed [AW-1:0] d_s6, dw_s7;
	logic signed [VW-1:0] rx [CORDIC_STAGES+1];
	logic signed [VW-1:0] ry [CORDIC_STAGES+1];
	logic signed [AW-1:0] rz [CORDIC_STAGES+1];
	logic signed [AW-1:0] rnd_r;
	logic [AW-15:0]       err_full;
	logic [plt_pkg::ERR_W-1:0] err_s9, err_d;

	always_ff @(posedge clk) begin
		d_s6 <= v2z[CORDIC_STAGES] - v1z[CORDIC_STAGES];
		if (d_s6 > plt_pkg::ANG_PI) begin
			dw_s7 <= d_s6 - plt_pkg::ANG_TWO_PI;
		end else if (d_s6 <= -plt_pkg::ANG_PI) begin
			dw_s7 <= d_s6 + plt_pkg::ANG_TWO_PI;
		end else begin
			dw_s7 <= d_s6;
		end
		// pi/2 - d, reduced by pi when above pi/2
		rz[0] <= (dw_s7[AW-1] ? -plt_pkg::ANG_HALF_PI : plt_pkg::ANG_HALF_PI) - dw_s7;
	end

	// Error: |r| rounded to Q1.16
	assign rnd_r = rz[0][AW-1] ? (AW'(8192) - rz[0]) : (rz[0] + AW'(8192));
	assign err_full = rnd_r[AW-1:14];

	always_ff @(posedge clk) begin
		err_s9 <= (err_full > (AW-14)'(plt_pkg::ERR_MAX)) ? plt_pkg::ERR_MAX
			: err_full[plt_pkg::ERR_W-1:0];
	end

	plt_delay #(.WIDTH(plt_pkg::ERR_W), .DEPTH(CORDIC_STAGES)) u_err_dly (
		.clk (clk), .d (err_s9), .q (err_d)
	);

	// Gain-compensated vector waits for the rotation angle
	plt_delay #(.WIDTH(2 * VW), .DEPTH(CORDIC_STAGES + 2)) u_gain_dly (
		.clk (clk), .d ({gx_s6, gy_s6}), .q ({rx[0], ry[0]})
	);

	// Rotation row
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
		plt_cordic_cell #(.SHIFT(i), .VECTORING(1'b0)) u_cell (
			.clk   (clk),
			.x_in  (rx[i]), .y_in (ry[i]), .z_in (rz[i]),
			.x_out (rx[i+1]), .y_out (ry[i+1]), .z_out (rz[i+1])
		);
	end

	// Shift count and side fields
	logic [plt_pkg::SH_W-1:0] sh_d;
	plt_pkg::side_t           side_d;

	plt_delay #(.WIDTH(plt_pkg::SH_W), .DEPTH(2 * CORDIC_STAGES + 4)) u_sh_dly (
		.clk (clk), .d (sh2), .q (sh_d)
	);

	plt_delay #(.WIDTH($bits(plt_pkg::side_t)), .DEPTH(2 * CORDIC_STAGES + 8)) u_side_dly (
		.clk (clk), .d (side_s1), .q (side_d)
	);

	// Stage 10: undo the normalize shift with round half up
	logic signed [VW-1:0] half;
	logic signed [VW-1:0] ux_s10, uy_s10;

	assign half = (sh_d == '0) ? '0 : (VW'(1) <<< (sh_d - 1'b1));

	always_ff @(posedge clk) begin
		ux_s10 <= (rx[CORDIC_STAGES] + half) >>> sh_d;
		uy_s10 <= (ry[CORDIC_STAGES] + half) >>> sh_d;
	end

	// Output stage: add the pivot, saturate, pass through degenerate requests
	localparam logic signed [VW:0] C_HI = (VW+1)'({1'b0, {(CB-1){1'b1}}});
	localparam logic signed [VW:0] C_LO = -C_HI - 1;

	logic signed [VW:0] nx, ny;
	logic               sat_x, sat_y;

	assign nx = (VW+1)'(side_d.px) + (VW+1)'(ux_s10);
	assign ny = (VW+1)'(side_d.py) + (VW+1)'(uy_s10);
	assign sat_x = (nx > C_HI) || (nx < C_LO);
	assign sat_y = (ny > C_HI) || (ny < C_LO);

	always_ff @(posedge clk) begin
		if (side_d.deg) begin
			result.lines_valid <= 1'b0;
			result.angle_error <= plt_pkg::ERR_MAX;
			result.is_satisfied <= 1'b0;
			result.new_end_x <= side_d.ex;
			result.new_end_y <= side_d.ey;
			result.was_saturated <= 1'b0;
		end else begin
			result.lines_valid <= 1'b1;
			result.angle_error <= err_d;
			result.is_satisfied <= err_d <= tol_q;
			result.new_end_x <= (nx > C_HI) ? C_HI[CB-1:0]
				: (nx < C_LO) ? C_LO[CB-1:0] : nx[CB-1:0];
			result.new_end_y <= (ny > C_HI) ? C_HI[CB-1:0]
				: (ny < C_LO) ? C_LO[CB-1:0] : ny[CB-1:0];
			result.was_saturated <= sat_x || sat_y;
		end
	end

endmodule

FILE: design/plt_cordic_cell.sv
// One CORDIC micro-rotation cell, vectoring or rotation mode, registered output.
module plt_cordic_cell #(
	parameter int SHIFT = 0,
	parameter bit VECTORING = 1'b1
) (
	input  logic                                clk,
	input  logic signed [plt_pkg::VEC_W-1:0]    x_in,
	input  logic signed [plt_pkg::VEC_W-1:0]    y_in,
	input  logic signed [plt_pkg::ANG_W-1:0]    z_in,
	output logic signed [plt_pkg::VEC_W-1:0]    x_out,
	output logic signed [plt_pkg::VEC_W-1:0]    y_out,
	output logic signed [plt_pkg::ANG_W-1:0]    z_out
);

	localparam logic signed [plt_pkg::ANG_W-1:0] ATAN = plt_pkg::atan_entry(SHIFT);

	logic signed [plt_pkg::VEC_W-1:0] xs;
	logic signed [plt_pkg::VEC_W-1:0] ys;
	logic                             ccw;

	// Vectoring drives y to zero, rotation drives z to zero
	assign xs = x_in >>> SHIFT;
	assign ys = y_in >>> SHIFT;
	assign ccw = VECTORING ? y_in[plt_pkg::VEC_W-1] : !z_in[plt_pkg::ANG_W-1];

	always_ff @(posedge clk) begin
		if (ccw) begin
			x_out <= x_in - ys;
			y_out <= y_in + xs;
			z_out <= z_in - ATAN;
		end else begin
			x_out <= x_in + ys;
			y_out <= y_in - xs;
			z_out <= z_in + ATAN;
		end
	end

endmodule

FILE: design/plt_norm.sv
// Three-stage normalizer: doubles a vector until its larger magnitude reaches 2^40.
module plt_norm (
	input  logic                                clk,
	input  logic signed [plt_pkg::VEC_W-1:0]    x_in,
	input  logic signed [plt_pkg::VEC_W-1:0]    y_in,
	output logic signed [plt_pkg::VEC_W-1:0]    x_out,
	output logic signed [plt_pkg::VEC_W-1:0]    y_out,
	output logic [plt_pkg::SH_W-1:0]            sh_out
);

	typedef struct packed {
		logic signed [plt_pkg::VEC_W-1:0] x;
		logic signed [plt_pkg::VEC_W-1:0] y;
		logic [plt_pkg::VEC_W-1:0]        ax;
		logic [plt_pkg::VEC_W-1:0]        ay;
		logic [plt_pkg::SH_W-1:0]         sh;
	} norm_t;

	// Shift left by b when both magnitudes are below 2^thr before it
	function automatic norm_t step(input norm_t v, input int unsigned thr, input int unsigned b);
		norm_t o;
		o = v;
		if (((v.ax >> thr) == '0) && ((v.ay >> thr) == '0)) begin
			o.x = v.x <<< b;
			o.y = v.y <<< b;
			o.ax = v.ax << b;
			o.ay = v.ay << b;
			o.sh = v.sh + plt_pkg::SH_W'(b);
		end
		return o;
	endfunction

	norm_t n0;
	norm_t n1_c;
	norm_t n2_c;
	norm_t n3_c;
	norm_t nrm_s2;
	norm_t nrm_s3;

	// Magnitudes and first coarse steps
	always_comb begin
		n0.x = x_in;
		n0.y = y_in;
		n0.ax = x_in[plt_pkg::VEC_W-1] ? -x_in : x_in;
		n0.ay = y_in[plt_pkg::VEC_W-1] ? -y_in : y_in;
		n0.sh = '0;
		n1_c = step(step(n0, plt_pkg::NORM_EXP - 32, 32), plt_pkg::NORM_EXP - 16, 16);
	end

	assign n2_c = step(step(nrm_s2, plt_pkg::NORM_EXP - 8, 8), plt_pkg::NORM_EXP - 4, 4);

	// Fine steps, then one last doubling brings the magnitude over the limit
	assign n3_c = step(step(step(nrm_s3, plt_pkg::NORM_EXP - 2, 2), plt_pkg::NORM_EXP - 1, 1),
		plt_pkg::NORM_EXP, 1);

	always_ff @(posedge clk) begin
		nrm_s2 <= n1_c;
		nrm_s3 <= n2_c;
		x_out <= n3_c.x;
		y_out <= n3_c.y;
		sh_out <= n3_c.sh;
	end

endmodule

FILE: design/plt_delay.sv
// Fixed-depth register shift line for fields that travel beside the datapath.
module plt_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] tap_q [DEPTH];

	always_ff @(posedge clk) begin
		tap_q[0] <= d;
		for (int i = 1; i < DEPTH; i++) begin
			tap_q[i] <= tap_q[i-1];
		end
	end

	assign q = tap_q[DEPTH-1];

endmodule

FILE: design/plt_checker.sv
// Port-level checker for the perpendicular line block and its bind.
module plt_checker #(
	parameter int LATENCY = 42
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input plt_pkg::request_t req,
	input logic              done,
	input plt_pkg::result_t  result
);

	localparam int CW = $clog2(LATENCY + 1);

	// Cycles since reset, saturating, so $past looks only at live edges
	logic [CW-1:0] cyc_q;
	logic          armed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc_q <= '0;
		end else if (cyc_q != CW'(LATENCY)) begin
			cyc_q <= cyc_q + 1'b1;
		end
	end

	assign armed = cyc_q == CW'(LATENCY);

	// Every request gives exactly one result after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		armed |-> (done == $past(start && !busy, LATENCY)))
		else $error("result strobe does not match request latency");

	// Degenerate result carries the fixed flags
	a_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.lines_valid) |->
		(result.angle_error == plt_pkg::ERR_MAX && !result.is_satisfied
		&& !result.was_saturated))
		else $error("degenerate result flags wrong");

	// Degenerate result passes the end point of that request through
	a_passthru: assert property (@(posedge clk) disable iff (!arst_n)
		(armed && done && !result.lines_valid) |->
		(result.new_end_x == $past(req.second_end_x, LATENCY)
		&& result.new_end_y == $past(req.second_end_y, LATENCY)))
		else $error("degenerate end point not passed through");

	// Error of a valid result never exceeds a quarter turn
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.lines_valid) |-> (result.angle_error <= 17'd102944))
		else $error("angle error out of range");

endmodule

bind perpendicular_line_enforce plt_checker #(.LATENCY(LATENCY)) u_plt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.result (result)
);

FILE: test/perpendicular_line_enforce_test.sv
// Testbench for perpendicular_line_enforce: directed table, then random predicted requests.
`timescale 1ns / 1ps

module perpendicular_line_enforce_test;

	localparam int STAGES = 16;
	localparam int LATENCY = 2 * STAGES + 10;
	localparam int SETTLE = LATENCY + 8;
	localparam int STALL_LIMIT = 3000;
	localparam int PHASE_ITEMS = 142;
	localparam longint GAIN = 64'd652032874;
	localparam longint HALF_TURN = 64'd3373259426;
	localparam longint QUARTER_TURN = 64'd1686629713;
	localparam logic signed [31:0] CMAX = 32'sh7fffffff;
	localparam logic signed [31:0] CMIN = 32'sh80000000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	plt_pkg::request_t req;
	logic cfg_we;
	logic [plt_pkg::ERR_W-1:0] cfg_data;
	logic done;
	plt_pkg::result_t result;

	plt_pkg::result_t expected_results[$];
	logic [plt_pkg::ERR_W-1:0] tol_copy;
	int errors = 0;
	int stall_cycles = 0;
	bit start_high;

	typedef struct {
		plt_pkg::request_t rq;
		bit typed;
		plt_pkg::result_t want;
	} row_t;

	row_t rows[$];

	longint atan_lut[16] = '{843314856, 497837829, 263043836, 133525158, 67021686,
		33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
		131071, 65535, 32767};

	perpendicular_line_enforce #(.CORDIC_STAGES(STAGES)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint mag64(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// scale the vector up until its larger component reaches 2^40
	function automatic int unsigned norm_up(inout longint x, inout longint y);
		longint m;
		int unsigned s;
		s = 0;
		m = (mag64(x) > mag64(y)) ? mag64(x) : mag64(y);
		if (m == 0)
			return 0;
		while (m < (64'sd1 <<< 40)) begin
			m = m * 2;
			s++;
		end
		x = x <<< s;
		y = y <<< s;
		return s;
	endfunction

	// CORDIC vectoring: direction of (x, y) in radians * 2^30
	function automatic longint heading(longint x, longint y);
		longint z, t, xs, ys;
		int unsigned s;
		z = 0;
		s = norm_up(x, y);
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = QUARTER_TURN;
			end else begin
				t = x; x = -y; y = t; z = -QUARTER_TURN;
			end
		end
		for (int i = 0; i < STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y < 0) begin
				x -= ys; y += xs; z -= atan_lut[i];
			end else begin
				x += ys; y -= xs; z += atan_lut[i];
			end
		end
		return z;
	endfunction

	function automatic longint scale_gain(longint v);
		longint hi, lo;
		hi = v >>> 20;
		lo = v - (hi <<< 20);
		return (hi * GAIN + ((lo * GAIN) >>> 20)) >>> 10;
	endfunction

	function automatic logic signed [31:0] clamp_coord(longint v, inout bit sat);
		if (v > longint'(CMAX)) begin
			v = CMAX; sat = 1'b1;
		end
		if (v < longint'(CMIN)) begin
			v = CMIN; sat = 1'b1;
		end
		return v[31:0];
	endfunction

	// expected correction of one request
	function automatic plt_pkg::result_t perp_predict(plt_pkg::request_t q);
		plt_pkg::result_t o;
		longint dx1, dy1, dx2, dy2, d, r, x, y, z, xs, ys, err, ux, uy;
		int unsigned s;
		bit sat;
		sat = 1'b0;
		dx1 = longint'(q.first_end_x) - longint'(q.first_start_x);
		dy1 = longint'(q.first_end_y) - longint'(q.first_start_y);
		dx2 = longint'(q.second_end_x) - longint'(q.second_start_x);
		dy2 = longint'(q.second_end_y) - longint'(q.second_start_y);
		if ((dx1 == 0 && dy1 == 0) || (dx2 == 0 && dy2 == 0)) begin
			o = '{lines_valid: 1'b0, angle_error: plt_pkg::ERR_MAX, is_satisfied: 1'b0,
				new_end_x: q.second_end_x, new_end_y: q.second_end_y, was_saturated: 1'b0};
			return o;
		end
		d = heading(dx2, dy2) - heading(dx1, dy1);
		if (d > HALF_TURN)
			d -= 2 * HALF_TURN;
		if (d <= -HALF_TURN)
			d += 2 * HALF_TURN;
		r = QUARTER_TURN - d;
		if (r > QUARTER_TURN)
			r -= HALF_TURN;
		err = (mag64(r) + (64'sd1 <<< 13)) >>> 14;
		if (err > 131071)
			err = 131071;
		x = dx2;
		y = dy2;
		s = norm_up(x, y);
		x = scale_gain(x);
		y = scale_gain(y);
		z = r;
		// CORDIC rotation by r
		for (int i = 0; i < STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= atan_lut[i];
			end else begin
				x += ys; y -= xs; z += atan_lut[i];
			end
		end
		if (s != 0) begin
			ux = (x + (64'sd1 <<< (s - 1))) >>> s;
			uy = (y + (64'sd1 <<< (s - 1))) >>> s;
		end else begin
			ux = x;
			uy = y;
		end
		o.lines_valid = 1'b1;
		o.angle_error = err[plt_pkg::ERR_W-1:0];
		o.is_satisfied = (err[plt_pkg::ERR_W-1:0] <= tol_copy);
		o.new_end_x = clamp_coord(longint'(q.second_start_x) + ux, sat);
		o.new_end_y = clamp_coord(longint'(q.second_start_y) + uy, sat);
		o.was_saturated = sat;
		return o;
	endfunction

	function automatic plt_pkg::request_t mk_req(int a, int b, int c, int d, int e, int f,
		int g, int h);
		plt_pkg::request_t q;
		q = '{a, b, c, d, e, f, g, h};
		return q;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			2: return $urandom_range(0, 1) ? CMAX : CMIN;
			default: return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
		endcase
	endfunction

	function automatic plt_pkg::request_t rand_req();
		plt_pkg::request_t q;
		int dx, dy;
		q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				q.first_start_x = rand_coord(); q.first_start_y = rand_coord();
				q.first_end_x = rand_coord(); q.first_end_y = rand_coord();
				q.second_start_x = rand_coord(); q.second_start_y = rand_coord();
				q.second_end_x = rand_coord(); q.second_end_y = rand_coord();
			end
			3, 4, 5: begin
				// close to perpendicular, so the tolerance decides
				dx = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
				dy = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
				q.first_start_x = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
				q.first_start_y = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
				q.first_end_x = q.first_start_x + dx;
				q.first_end_y = q.first_start_y + dy;
				q.second_start_x = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
				q.second_start_y = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
				q.second_end_x = q.second_start_x - dy + $signed($urandom_range(0, 8)) - 4;
				q.second_end_y = q.second_start_y + dx + $signed($urandom_range(0, 8)) - 4;
			end
			6: begin
				// degenerate segment
				if ($urandom_range(0, 1)) begin
					q.first_end_x = q.first_start_x; q.first_end_y = q.first_start_y;
				end else begin
					q.second_end_x = q.second_start_x; q.second_end_y = q.second_start_y;
				end
			end
			7: begin
				// parallel, antiparallel or mirrored in one axis
				dx = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
				dy = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
				q.first_start_x = 0; q.first_start_y = 0;
				q.first_end_x = dx; q.first_end_y = dy;
				q.second_start_x = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
				q.second_start_y = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
				q.second_end_x = q.second_start_x + ($urandom_range(0, 1) ? dx : -dx);
				q.second_end_y = q.second_start_y + ($urandom_range(0, 1) ? dy : -dy);
			end
			default: ;
		endcase
		return q;
	endfunction

	// one request: hold start until taken, leave start high for a back-to-back follower
	task automatic send_request(plt_pkg::request_t q, bit typed, plt_pkg::result_t want,
		int unsigned gap);
		if (start_high && gap != 0) begin
			start <= 1'b0;
			start_high = 1'b0;
		end
		repeat (gap) @(negedge clk);
		start <= 1'b1;
		start_high = 1'b1;
		req <= q;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		expected_results.push_back(typed ? want : perp_predict(q));
		@(negedge clk);
	endtask

	task automatic drain_and_write(logic [plt_pkg::ERR_W-1:0] tol);
		if (start_high) begin
			start <= 1'b0;
			start_high = 1'b0;
		end
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= tol;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// result check and tolerance shadow
	always @(posedge clk) begin
		plt_pkg::result_t want;
		if (!arst_n)
			tol_copy <= plt_pkg::TOL_RESET;
		else if (cfg_we)
			tol_copy <= cfg_data;
		if (done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with no request pending: %p", $time, result);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (result.lines_valid !== want.lines_valid) begin
					$display("%0t: lines_valid exp %0b got %0b", $time,
						want.lines_valid, result.lines_valid);
					errors++;
				end
				if (result.angle_error !== want.angle_error) begin
					$display("%0t: angle_error exp %0d got %0d", $time,
						want.angle_error, result.angle_error);
					errors++;
				end
				if (result.is_satisfied !== want.is_satisfied) begin
					$display("%0t: is_satisfied exp %0b got %0b", $time,
						want.is_satisfied, result.is_satisfied);
					errors++;
				end
				if (result.new_end_x !== want.new_end_x) begin
					$display("%0t: new_end_x exp %0d got %0d", $time,
						want.new_end_x, result.new_end_x);
					errors++;
				end
				if (result.new_end_y !== want.new_end_y) begin
					$display("%0t: new_end_y exp %0d got %0d", $time,
						want.new_end_y, result.new_end_y);
					errors++;
				end
				if (result.was_saturated !== want.was_saturated) begin
					$display("%0t: was_saturated exp %0b got %0b", $time,
						want.was_saturated, result.was_saturated);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no traffic
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("perpendicular_line_enforce_test: errors");
			$finish;
		end
	end

	initial begin
		plt_pkg::result_t degen;
		logic [plt_pkg::ERR_W-1:0] tols[6];
		bit steady;
		plt_pkg::request_t q;
		start_high = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table, degenerate rows typed in
		q = mk_req(0, 0, 0, 0, 0, 0, 0, 0);
		degen = '{1'b0, plt_pkg::ERR_MAX, 1'b0, 32'sd0, 32'sd0, 1'b0};
		rows.push_back('{q, 1'b1, degen});
		q = mk_req(5, 5, 5, 5, 0, 0, CMAX, CMIN);
		degen = '{1'b0, plt_pkg::ERR_MAX, 1'b0, CMAX, CMIN, 1'b0};
		rows.push_back('{q, 1'b1, degen});
		q = mk_req(CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN);
		degen = '{1'b0, plt_pkg::ERR_MAX, 1'b0, CMIN, CMIN, 1'b0};
		rows.push_back('{q, 1'b1, degen});
		rows.push_back('{mk_req(0, 0, 65536, 0, 0, 0, 0, 65536), 1'b0, degen});
		rows.push_back('{mk_req(0, 0, 65536, 0, 0, 0, 65536, 0), 1'b0, degen});
		rows.push_back('{mk_req(0, 0, 65536, 0, 0, 0, -65536, 0), 1'b0, degen});
		rows.push_back('{mk_req(0, 0, -1, 0, 7, 7, 7, 8), 1'b0, degen});
		rows.push_back('{mk_req(0, 0, -3, -4, 100, 100, 104, 97), 1'b0, degen});
		rows.push_back('{mk_req(0, 0, 1, 1, 0, 0, -1, 1), 1'b0, degen});
		rows.push_back('{mk_req(0, 0, 1, 0, 1, 0, 1, -1), 1'b0, degen});
		rows.push_back('{mk_req(CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN), 1'b0, degen});
		rows.push_back('{mk_req(CMAX, 0, CMIN, 0, CMAX, CMAX, CMIN, CMAX), 1'b0, degen});
		rows.push_back('{mk_req(0, 0, 0, 1, CMIN, CMIN, CMAX, CMIN), 1'b0, degen});
		rows.push_back('{mk_req(0, 0, 1, 0, CMAX, CMAX, CMIN, CMIN), 1'b0, degen});
		rows.push_back('{mk_req(0, 0, 1000, 3, 0, 0, -3, 1000), 1'b0, degen});
		rows.push_back('{mk_req(-1, -1, 0, 0, 2, 2, 1, 3), 1'b0, degen});
		foreach (rows[i])
			send_request(rows[i].rq, rows[i].typed, rows[i].want, pick_gap());

		// random phases over several tolerance settings
		tols[0] = 17'd1;
		tols[1] = 17'd102944;
		tols[2] = 17'd0;
		tols[3] = '1;
		tols[4] = plt_pkg::ERR_W'($urandom_range(1, 102944));
		tols[5] = 17'd66;
		foreach (tols[p]) begin
			drain_and_write(tols[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0)
					steady = ($urandom_range(0, 3) == 0);
				send_request(rand_req(), 1'b0, degen, steady ? 0 : pick_gap());
			end
		end

		if (start_high) begin
			start <= 1'b0;
			start_high = 1'b0;
		end
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (errors == 0) begin
			$display("perpendicular_line_enforce_test: clean");
		end else begin
			$display("perpendicular_line_enforce_test: errors");
		end
		$finish;
	end

endmodule

FILE: sim.f
design/plt_pkg.sv
design/plt_cordic_cell.sv
design/plt_norm.sv
design/plt_delay.sv
design/perpendicular_line_enforce.sv
design/plt_checker.sv
test/perpendicular_line_enforce_test.sv
